>>> hw/rtl/pi_controller_clamped_unit_defines.svh
// Assertion macros shared by the PI controller RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef PI_CONTROLLER_CLAMPED_UNIT_DEFINES_SVH
`define PI_CONTROLLER_CLAMPED_UNIT_DEFINES_SVH

// Property checked on every rising clock edge outside of reset.
`define PICTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, outside of reset.
`define PICTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pictl_pkg.sv
// Types, constants and the microcode table of the PI controller.
// Used by the sequencer, the datapath and the top level.
package pictl_pkg;

  localparam int unsigned SIG_W    = 16;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned LIM_W    = 15;
  localparam int unsigned ERR_W    = 17;
  localparam int unsigned PROD_W   = 41;
  localparam int unsigned ACC_W    = 42;
  localparam int unsigned INT_W    = 32;
  localparam int unsigned FRAC_SH  = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned STEP_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX  = 3'd5;

  localparam logic [STEP_W-1:0] STEP_ERR       = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_KI    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_INT_ADD   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_INT_CLAMP = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SUM       = 3'd4;
  localparam logic [STEP_W-1:0] STEP_OUT       = 3'd5;
  localparam logic [STEP_W-1:0] STEP_CLEAR     = 3'd6;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_INT_ADD,
    ACC_PROD_ADD,
    ACC_CLAMP_INT,
    ACC_CLAMP_OUT
  } acc_op_e;

  typedef struct packed {
    logic    ld_err;
    logic    mul_kp;
    logic    ld_prod;
    acc_op_e acc_op;
    logic    wr_int;
    logic    clr_int;
    logic    emit;
    logic    jmp_clr;
    logic    last;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '0;
    c.acc_op = ACC_HOLD;
    unique case (step)
      STEP_ERR: begin
        c.ld_err  = 1'b1;
        c.jmp_clr = 1'b1;
      end
      STEP_MUL_KI: begin
        c.ld_prod = 1'b1;
      end
      STEP_INT_ADD: begin
        c.acc_op  = ACC_INT_ADD;
        c.mul_kp  = 1'b1;
        c.ld_prod = 1'b1;
      end
      STEP_INT_CLAMP: begin
        c.acc_op = ACC_CLAMP_INT;
        c.wr_int = 1'b1;
      end
      STEP_SUM: begin
        c.acc_op = ACC_PROD_ADD;
      end
      STEP_OUT: begin
        c.acc_op = ACC_CLAMP_OUT;
        c.emit   = 1'b1;
        c.last   = 1'b1;
      end
      STEP_CLEAR: begin
        c.clr_int = 1'b1;
        c.emit    = 1'b1;
        c.last    = 1'b1;
      end
      default: begin
        c.last = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/pictl_seq.sv
// Microcode sequencer: step counter, table lookup and the jump on a clear item.
// Depends on pictl_pkg.
module pictl_seq import pictl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  step_en_i,
  input  logic  is_clear_i,
  output ctrl_t ctrl_o,
  output logic  busy_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;

  assign ctrl_o = ucode(step_q);
  assign busy_o = busy_q;

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    priority if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_ERR;
    end else if (busy_q && step_en_i) begin
      priority if (ctrl_o.jmp_clr && is_clear_i) begin
        step_d = STEP_CLEAR;
      end else if (ctrl_o.last) begin
        busy_d = 1'b0;
        step_d = STEP_ERR;
      end else begin
        step_d = step_q + 1'b1;
      end
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_ERR;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

endmodule

>>> hw/rtl/pictl_dp.sv
// Datapath: error register, shared multiplier, accumulator, clamps, integrator.
// Depends on pictl_pkg; driven by the control word of pictl_seq.
module pictl_dp import pictl_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  ctrl_t                    ctrl_i,
  input  logic signed [SIG_W-1:0]  setpoint_i,
  input  logic        [GAIN_W-1:0] prop_gain_i,
  input  logic        [GAIN_W-1:0] int_gain_i,
  input  logic        [LIM_W-1:0]  int_limit_i,
  input  logic signed [SIG_W-1:0]  drive_min_i,
  input  logic signed [SIG_W-1:0]  drive_max_i,
  input  logic signed [SIG_W-1:0]  measured_i,
  output logic signed [SIG_W-1:0]  drive_o
);

  logic signed [ERR_W-1:0]  err_q, err_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [INT_W-1:0]  integ_q, integ_d;

  logic        [GAIN_W-1:0] gain_sel;
  logic signed [GAIN_W:0]   mul_b;
  logic signed [ACC_W-1:0]  prod_full;
  logic signed [ACC_W-1:0]  lim_pos, lim_neg, hi, lo;
  logic signed [ACC_W-1:0]  clamp_int, clamp_hi, clamp_out;

  assign err_d = $signed({setpoint_i[SIG_W-1], setpoint_i})
               - $signed({measured_i[SIG_W-1], measured_i});

  assign gain_sel  = ctrl_i.mul_kp ? prop_gain_i : int_gain_i;
  assign mul_b     = $signed({1'b0, gain_sel});
  assign prod_full = err_q * mul_b;

  assign lim_pos = $signed({{(ACC_W-LIM_W-FRAC_SH){1'b0}}, int_limit_i, {FRAC_SH{1'b0}}});
  assign lim_neg = -lim_pos;
  assign hi = $signed({{(ACC_W-SIG_W-FRAC_SH){drive_max_i[SIG_W-1]}}, drive_max_i,
                       {FRAC_SH{1'b0}}});
  assign lo = $signed({{(ACC_W-SIG_W-FRAC_SH){drive_min_i[SIG_W-1]}}, drive_min_i,
                       {FRAC_SH{1'b0}}});

  assign clamp_int = (acc_q > lim_pos) ? lim_pos : ((acc_q < lim_neg) ? lim_neg : acc_q);
  assign clamp_hi  = (acc_q > hi) ? hi : acc_q;
  assign clamp_out = (clamp_hi < lo) ? lo : clamp_hi;

  // The clamped sum lies within 32 signed bits, so this select is the floor.
  assign drive_o = ctrl_i.clr_int ? '0 : clamp_out[FRAC_SH+SIG_W-1:FRAC_SH];

  always_comb begin
    unique case (ctrl_i.acc_op)
      ACC_INT_ADD:   acc_d = ACC_W'(integ_q) + ACC_W'(prod_q);
      ACC_PROD_ADD:  acc_d = acc_q + ACC_W'(prod_q);
      ACC_CLAMP_INT: acc_d = clamp_int;
      ACC_CLAMP_OUT: acc_d = clamp_out;
      default:       acc_d = acc_q;
    endcase
  end

  always_comb begin
    integ_d = integ_q;
    priority if (ctrl_i.clr_int) begin
      integ_d = '0;
    end else if (ctrl_i.wr_int) begin
      integ_d = clamp_int[INT_W-1:0];
    end else begin
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ctrl_i.ld_err) begin
        err_q <= err_d;
      end
      if (ctrl_i.ld_prod) begin
        prod_q <= prod_full[PROD_W-1:0];
      end
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (en_i) begin
      integ_q <= integ_d;
    end
  end

endmodule

>>> hw/rtl/pi_controller_clamped_unit.sv
// Top level of the clamped PI controller: configuration registers, handshakes,
// output register. Depends on pictl_pkg, pictl_seq, pictl_dp and the defines header.
//
//  Channel  Direction  Handshake               Payload
//  in       sink       in_valid_i / in_stall_o  kind_i, measured_i
//  out      source     out_valid_o / out_stall_i drive_o
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample item runs six microcode steps through one shared multiplier and a clear
// item takes two steps; a new item is accepted only once the sequencer is idle again.
// The result is registered and the next item is accepted while it waits.
// A stalled result holds the sequencer on its final step only.
// Reset is asynchronous and loads the register defaults and a zero integrator.
`include "pi_controller_clamped_unit_defines.svh"

module pi_controller_clamped_unit import pictl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic signed [SIG_W-1:0] measured_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SIG_W-1:0] drive_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DAT_W-1:0]    cfg_data_i
);

  logic signed [SIG_W-1:0]  setpoint_q, drive_min_q, drive_max_q;
  logic        [GAIN_W-1:0] prop_gain_q, int_gain_q;
  logic        [LIM_W-1:0]  int_limit_q;

  logic                    kind_q;
  logic signed [SIG_W-1:0] meas_q;
  logic                    out_valid_q, out_valid_d;
  logic signed [SIG_W-1:0] drive_q;
  logic signed [SIG_W-1:0] dp_drive;

  ctrl_t ctrl;
  logic  busy, accept, hold, step_en, emit_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign accept      = in_valid_i && !busy;
  assign hold        = ctrl.emit && out_valid_q && out_stall_i;
  assign step_en     = busy && !hold;
  assign emit_fire   = step_en && ctrl.emit;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  pictl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .step_en_i  (step_en),
    .is_clear_i (kind_q),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  pictl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (step_en),
    .ctrl_i      (ctrl),
    .setpoint_i  (setpoint_q),
    .prop_gain_i (prop_gain_q),
    .int_gain_i  (int_gain_q),
    .int_limit_i (int_limit_q),
    .drive_min_i (drive_min_q),
    .drive_max_i (drive_max_q),
    .measured_i  (meas_q),
    .drive_o     (dp_drive)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q  <= '0;
      prop_gain_q <= '0;
      int_gain_q  <= '0;
      int_limit_q <= '1;
      drive_min_q <= '0;
      drive_max_q <= SIG_W'(4096);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SETPOINT:  setpoint_q  <= cfg_data_i[SIG_W-1:0];
        REG_PROP_GAIN: prop_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_INT_GAIN:  int_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_INT_LIMIT: int_limit_q <= cfg_data_i[LIM_W-1:0];
        REG_DRIVE_MIN: drive_min_q <= cfg_data_i[SIG_W-1:0];
        REG_DRIVE_MAX: drive_max_q <= cfg_data_i[SIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      meas_q <= measured_i;
    end
    if (emit_fire) begin
      drive_q <= dp_drive;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  `PICTL_ASSERT_NEXT(a_accept_starts, accept, busy, "Accepted item did not start the sequencer.")
  `PICTL_ASSERT(a_result_from_emit, $rose(out_valid_o) |-> $past(busy && ctrl.emit),
                "Result appeared without an emit step.")
  `PICTL_ASSERT(a_clear_gives_zero,
                ($rose(out_valid_o) && $past(ctrl.clr_int)) |-> (drive_o == '0),
                "Clear item produced a nonzero drive.")

endmodule
